// ----- rtl/mhpq_pkg.sv -----
package mhpq_pkg;

  localparam int unsigned Capacity = 1024;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned SlotW    = AddrW + 1;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_DECREASE = 2'd2,
    OP_PEEK     = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_OVERFLOW    = 3'd1,
    ST_EMPTY       = 3'd2,
    ST_NOT_SMALLER = 3'd3,
    ST_BAD_SLOT    = 3'd4
  } status_e;

  // Command passed from the front end to the heap engine
  typedef struct packed {
    opcode_e            op;
    logic signed [31:0] key;
    logic signed [31:0] value;
    logic [SlotW-1:0]   slot;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] out_key;
    logic signed [31:0] out_value;
    logic [SlotW-1:0]   final_slot;
    logic [SlotW-1:0]   count;
  } rsp_t;

  localparam int unsigned CmdW = $bits(cmd_t);
  localparam int unsigned RspW = $bits(rsp_t);

endpackage

// ----- rtl/min_heap_priority_queue_top.sv -----
// Binary min-heap priority queue of 1024 key/value entries.
// Input stream: tuser carries the opcode (insert, extract-min, decrease-key,
// peek); tdata carries key, value and the 1-based slot for decrease-key.
// Output stream: one transfer per command; tuser carries the status,
// tdata carries out_key, out_value, final_slot and the entry count.
// A front end queues up to two commands; the heap engine runs one command
// at a time against a single key/value memory (one write, two reads a cycle).
// Overflow, empty and bad-slot errors end in the read state, and peek and
// not-smaller errors in the check state; inserts, decreases and extracts go
// on to sift, one heap level per pass through a read and a compare state.
// The engine frees up once its result is in the output register, so the sift loop
// sets the rate. Reset empties the heap at once; memory needs no clearing.
// A stalled receiver holds the result in the output register; the engine
// then waits, and the front queue keeps accepting until it holds two commands.
module min_heap_priority_queue_top import mhpq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // key[31:0], value[63:32], slot[74:64]
  input  logic [1:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // out_key, out_value, final_slot, count
  output logic [2:0]  m_axis_tuser   // status
);

  logic cmd_valid, cmd_ready, rsp_valid, rsp_ready;
  cmd_t cmd;
  rsp_t rsp;

  mhpq_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .s_axis_tuser, .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  mhpq_engine u_engine (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .rsp_valid_o(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_o(rsp)
  );

  mhpq_out u_out (
    .clk_i, .rst_ni, .rsp_valid_i(rsp_valid), .rsp_ready_o(rsp_ready),
    .rsp_i(rsp), .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

endmodule

// ----- rtl/mhpq_front.sv -----
module mhpq_front import mhpq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [79:0]     s_axis_tdata,
  input  logic [1:0]      s_axis_tuser,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output cmd_t            cmd_o
);

  // Two-entry command queue
  cmd_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push, pop;
  cmd_t       cmd_in;

  assign cmd_in.op    = opcode_e'(s_axis_tuser);
  assign cmd_in.key   = s_axis_tdata[31:0];
  assign cmd_in.value = s_axis_tdata[63:32];
  assign cmd_in.slot  = s_axis_tdata[64 +: SlotW];

  assign s_axis_tready = (fill_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (fill_q != 2'd0);
  assign pop           = cmd_valid_o && cmd_ready_i;
  assign cmd_o         = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + 2'(push) - 2'(pop);
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= cmd_in;
  end

endmodule

// ----- rtl/mhpq_engine.sv -----
module mhpq_engine import mhpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010, // issue read of root or target slot
    S_CHK   = 9'b000000100, // evaluate read data for start of op
    S_LAST  = 9'b000001000, // read root's children for extract
    S_UPRD  = 9'b000010000, // read parent
    S_UPCMP = 9'b000100000,
    S_DNRD  = 9'b001000000, // read children
    S_DNCMP = 9'b010000000,
    S_RSP   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Key/value memory, two read ports and one write port
  logic [63:0]      mem [Capacity];
  logic             we;
  logic [AddrW-1:0] wa, ra0, ra1;
  logic [63:0]      wd, rd0_q, rd1_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd0_q <= mem[ra0];
    rd1_q <= mem[ra1];
  end

  cmd_t             cmd_q;
  logic [SlotW-1:0] cnt_q, cnt_d;
  logic [SlotW-1:0] pos_q, pos_d;
  logic [63:0]      ent_q, ent_d;   // entry being sifted
  rsp_t             rsp_q, rsp_d;

  logic [SlotW:0] lch, rch;
  logic [SlotW-1:0] par;
  logic l_ok, r_ok, l_lt, r_lt, rl_lt;
  logic signed [31:0] ek, k0, k1;

  assign par  = pos_q >> 1;
  assign lch  = {pos_q, 1'b0};
  assign rch  = {pos_q, 1'b1};
  assign ek   = ent_q[31:0];
  assign k0   = rd0_q[31:0];
  assign k1   = rd1_q[31:0];
  assign l_ok = (lch <= {1'b0, cnt_q});
  assign r_ok = (rch <= {1'b0, cnt_q});
  assign l_lt = l_ok && (k0 < ek);
  assign rl_lt = k1 < k0;
  assign r_lt = r_ok && (l_lt ? rl_lt : (k1 < ek));

  assign cmd_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RSP);
  assign rsp_o       = rsp_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    ent_d   = ent_q;
    rsp_d   = rsp_q;
    we      = 1'b0;
    wa      = '0;
    wd      = ent_q;
    ra0     = '0;
    ra1     = '0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) state_d = S_RD;
      end
      S_RD: begin
        rsp_d = '{status: ST_OK, out_key: '0, out_value: '0,
                  final_slot: '0, count: cnt_q};
        ra0   = AddrW'(cmd_q.slot - 1'b1);
        ra1   = AddrW'(cnt_q - 1'b1);
        case (cmd_q.op)
          OP_INSERT: begin
            if (cnt_q == SlotW'(Capacity)) begin
              rsp_d.status = ST_OVERFLOW;
              state_d = S_RSP;
            end else begin
              cnt_d = cnt_q + 1'b1;
              pos_d = cnt_q + 1'b1;
              ent_d = {cmd_q.value, cmd_q.key};
              rsp_d.count = cnt_q + 1'b1;
              state_d = S_UPRD;
            end
          end
          OP_DECREASE: begin
            if (cmd_q.slot == '0 || cmd_q.slot > cnt_q) begin
              rsp_d.status = ST_BAD_SLOT;
              state_d = S_RSP;
            end else begin
              state_d = S_CHK;
            end
          end
          default: begin
            ra0 = '0;
            if (cnt_q == '0) begin
              rsp_d.status = ST_EMPTY;
              state_d = S_RSP;
            end else begin
              state_d = S_CHK;
            end
          end
        endcase
      end
      S_CHK: begin
        case (cmd_q.op)
          OP_DECREASE: begin
            if (!(cmd_q.key < k0)) begin
              rsp_d.status = ST_NOT_SMALLER;
              state_d = S_RSP;
            end else begin
              pos_d = cmd_q.slot;
              ent_d = {rd0_q[63:32], cmd_q.key};
              state_d = S_UPRD;
            end
          end
          OP_EXTRACT: begin
            rsp_d.out_key   = k0;
            rsp_d.out_value = rd0_q[63:32];
            ent_d = rd1_q;
            cnt_d = cnt_q - 1'b1;
            rsp_d.count = cnt_q - 1'b1;
            pos_d = SlotW'(1);
            state_d = S_LAST;
          end
          default: begin
            rsp_d.out_key   = k0;
            rsp_d.out_value = rd0_q[63:32];
            state_d = S_RSP;
          end
        endcase
      end
      S_LAST: begin
        // Start sift down from the root with the former last entry
        ra0 = AddrW'({pos_q, 1'b0} - 1'b1);
        ra1 = AddrW'({pos_q, 1'b1} - 1'b1);
        state_d = S_DNCMP;
      end
      S_UPRD: begin
        ra0 = AddrW'(par - 1'b1);
        if (pos_q == SlotW'(1)) begin
          we = 1'b1;
          wa = AddrW'(pos_q - 1'b1);
          rsp_d.final_slot = pos_q;
          state_d = S_RSP;
        end else begin
          state_d = S_UPCMP;
        end
      end
      S_UPCMP: begin
        we = 1'b1;
        wa = AddrW'(pos_q - 1'b1);
        if (ek < k0) begin
          // Move parent down, continue upward
          wd = rd0_q;
          pos_d = par;
          state_d = S_UPRD;
        end else begin
          rsp_d.final_slot = pos_q;
          state_d = S_RSP;
        end
      end
      S_DNRD: begin
        ra0 = AddrW'(lch - 1'b1);
        ra1 = AddrW'(rch - 1'b1);
        state_d = S_DNCMP;
      end
      S_DNCMP: begin
        we = (cnt_q != '0);
        wa = AddrW'(pos_q - 1'b1);
        if (r_lt) begin
          wd = rd1_q;
          pos_d = SlotW'(rch);
          state_d = S_DNRD;
        end else if (l_lt) begin
          wd = rd0_q;
          pos_d = SlotW'(lch);
          state_d = S_DNRD;
        end else begin
          state_d = S_RSP;
        end
      end
      S_RSP: begin
        if (rsp_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) cmd_q <= cmd_i;
    pos_q <= pos_d;
    ent_q <= ent_d;
    rsp_q <= rsp_d;
  end

endmodule

// ----- rtl/mhpq_out.sv -----
module mhpq_out import mhpq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rsp_valid_i,
  output logic        rsp_ready_o,
  input  rsp_t        rsp_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser
);

  // Output register: hold result until the receiver takes it
  logic valid_q;
  rsp_t rsp_q;

  assign rsp_ready_o   = !valid_q || m_axis_tready;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = rsp_q.status;
  assign m_axis_tdata  = {2'b0, rsp_q.count, rsp_q.final_slot,
                          rsp_q.out_value, rsp_q.out_key};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (rsp_ready_o) valid_q <= rsp_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready_o && rsp_valid_i) rsp_q <= rsp_i;
  end

endmodule

// ----- test/tb_min_heap_priority_queue_top.sv -----
module tb_min_heap_priority_queue_top import mhpq_pkg::*; ();

  localparam int HeapCap    = Capacity;
  localparam int IdleLimit  = 20000;
  localparam int MaxReports = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;   // key[31:0], value[63:32], slot[74:64]
  logic [1:0]  s_axis_tuser;   // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [87:0] m_axis_tdata;   // out_key[31:0], out_value[63:32], final_slot[74:64], count[85:75]
  logic [2:0]  m_axis_tuser;   // status

  typedef struct packed {
    status_e            status;
    logic signed [31:0] out_key;
    logic signed [31:0] out_value;
    logic [10:0]        final_slot;
    logic [10:0]        count;
  } heap_rsp_t;

  // shadow heap
  logic signed [31:0] sh_key [1:HeapCap];
  logic signed [31:0] sh_val [1:HeapCap];
  int unsigned        sh_count;

  heap_rsp_t rsp_queue[$];

  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_cycles;
  int mismatch_count;
  int idle_cycles;
  bit timed_out;

  min_heap_priority_queue_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // swap two shadow slots
  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic signed [31:0] t;
    t = sh_key[a]; sh_key[a] = sh_key[b]; sh_key[b] = t;
    t = sh_val[a]; sh_val[a] = sh_val[b]; sh_val[b] = t;
  endfunction

  function automatic int unsigned bubble_up(int unsigned s);
    while (s > 1 && sh_key[s] < sh_key[s / 2]) begin
      swap_entries(s, s / 2);
      s = s / 2;
    end
    return s;
  endfunction

  function automatic void bubble_down();
    int unsigned s, l, r, best;
    s = 1;
    forever begin
      l = 2 * s;
      r = l + 1;
      best = s;
      if (l <= sh_count && sh_key[l] < sh_key[s]) best = l;
      if (r <= sh_count && sh_key[r] < sh_key[best]) best = r;
      if (best == s) return;
      swap_entries(s, best);
      s = best;
    end
  endfunction

  // apply one command to the shadow heap and return the expected response
  function automatic heap_rsp_t heap_apply(opcode_e op, logic signed [31:0] key,
                                           logic signed [31:0] value, logic [10:0] slot);
    heap_rsp_t r;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (sh_count >= HeapCap) r.status = ST_OVERFLOW;
        else begin
          sh_count++;
          sh_key[sh_count] = key;
          sh_val[sh_count] = value;
          r.final_slot = 11'(bubble_up(sh_count));
        end
      end
      OP_EXTRACT, OP_PEEK: begin
        if (sh_count == 0) r.status = ST_EMPTY;
        else begin
          r.out_key = sh_key[1];
          r.out_value = sh_val[1];
          if (op == OP_EXTRACT) begin
            sh_key[1] = sh_key[sh_count];
            sh_val[1] = sh_val[sh_count];
            sh_count--;
            bubble_down();
          end
        end
      end
      default: begin
        if (slot < 1 || slot > sh_count) r.status = ST_BAD_SLOT;
        else if (!(key < sh_key[slot])) r.status = ST_NOT_SMALLER;
        else begin
          sh_key[slot] = key;
          r.final_slot = 11'(bubble_up(slot));
        end
      end
    endcase
    r.count = 11'(sh_count);
    return r;
  endfunction

  // offer one command and hold it until the transfer
  task automatic send_cmd(opcode_e op, logic signed [31:0] key,
                          logic signed [31:0] value, logic [10:0] slot);
    // drop valid for the idle cycles before this command
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, slot, value, key};
    do @(posedge clk_i); while (!s_axis_tready);
    rsp_queue.push_back(heap_apply(op, key, value, slot));
  endtask

  // stop offering and wait until every expected result has come
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (rsp_queue.size() != 0 && !timed_out);
  endtask

  function automatic logic signed [31:0] rand_key();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'($urandom_range(20)) - 10;
      default: return $urandom;
    endcase
  endfunction

  // one random command, with ins_pct percent of them inserts
  task automatic send_random(int ins_pct);
    int pick;
    logic [10:0] slot;
    pick = $urandom_range(99);
    slot = (sh_count > 0 && $urandom_range(9) != 0) ? 11'($urandom_range(sh_count, 1))
                                                    : 11'($urandom);
    if (pick < ins_pct) send_cmd(OP_INSERT, rand_key(), $urandom, slot);
    else if (pick < ins_pct + (100 - ins_pct) / 3) send_cmd(OP_EXTRACT, $urandom, $urandom, slot);
    else if (pick < ins_pct + 2 * (100 - ins_pct) / 3) begin
      if (slot >= 1 && slot <= sh_count && $urandom_range(3) != 0)
        send_cmd(OP_DECREASE, sh_key[slot] - 32'($urandom_range(1000)), $urandom, slot);
      else send_cmd(OP_DECREASE, rand_key(), $urandom, slot);
    end else send_cmd(OP_PEEK, $urandom, $urandom, slot);
  endtask

  // empty-heap errors, field extremes, equal keys
  task automatic test_directed();
    send_cmd(OP_EXTRACT, 0, 0, 0);
    send_cmd(OP_PEEK, 0, 0, 0);
    send_cmd(OP_DECREASE, 5, 0, 1);
    send_cmd(OP_INSERT, 32'sh7fff_ffff, 32'sh8000_0000, 11'h7ff);
    send_cmd(OP_INSERT, 32'sh8000_0000, 32'sh7fff_ffff, 0);
    send_cmd(OP_INSERT, 7, -1, 0);
    send_cmd(OP_INSERT, 7, 1, 0);
    send_cmd(OP_INSERT, 32'sh7fff_ffff, 3, 0);
    send_cmd(OP_PEEK, 0, 0, 0);
    send_cmd(OP_DECREASE, 7, 0, 3);
    send_cmd(OP_DECREASE, 8, 0, 3);
    send_cmd(OP_DECREASE, 32'sh8000_0000, 0, 5);
    send_cmd(OP_DECREASE, -4, 0, 0);
    send_cmd(OP_DECREASE, -4, 0, 6);
    send_cmd(OP_DECREASE, -4, 0, 11'h7ff);
    send_cmd(OP_DECREASE, -9, 0, 4);
    repeat (6) send_cmd(OP_EXTRACT, 0, 0, 0);
    send_cmd(OP_PEEK, 0, 0, 0);
    wait_drained();
  endtask

  // fill to capacity, overflow, decrease-key at and past the last slot, then take a run of minimums off the full heap
  task automatic test_full_heap();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (sh_count < HeapCap) send_cmd(OP_INSERT, $urandom_range(60000) - 30000, $urandom, 0);
    send_cmd(OP_INSERT, 32'sh8000_0000, 1, 0);
    send_cmd(OP_DECREASE, 32'sh8000_0000, 0, 11'(HeapCap));
    send_cmd(OP_DECREASE, 0, 0, 11'(HeapCap + 1));
    wait_drained();
    repeat (80) send_cmd(OP_EXTRACT, 0, 0, 0);
    send_cmd(OP_PEEK, 0, 0, 0);
    wait_drained();
  endtask

  // receiver stops for a long stretch while commands keep coming
  task automatic test_backpressure();
    recv_hold_cycles = 400;
    repeat (20) send_random(70);
    wait_drained();
  endtask

  task automatic test_random(int n, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n) send_random(sh_count < 30 ? 65 : 40);
    wait_drained();
  endtask

  // receiver: random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (recv_hold_cycles > 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      m_axis_tready    <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    heap_rsp_t got, exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status     = status_e'(m_axis_tuser);
      got.out_key    = m_axis_tdata[31:0];
      got.out_value  = m_axis_tdata[63:32];
      got.final_slot = m_axis_tdata[74:64];
      got.count      = m_axis_tdata[85:75];
      if (rsp_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) $display("unexpected result transfer %p", got);
      end else begin
        exp = rsp_queue.pop_front();
        if (got != exp) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("mismatch: expected %p, got %p", exp, got);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IdleLimit) begin
      timed_out = 1'b1;
      $display("[min_heap_priority_queue_top] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold_cycles = 0;
    mismatch_count = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    sh_count = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(100, 36, 62);
    test_random(100, 62, 36);
    test_backpressure();
    test_random(60, 0, 0);
    test_full_heap();
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0 && rsp_queue.size() == 0)
      $display("[min_heap_priority_queue_top] OK");
    else
      $display("[min_heap_priority_queue_top] ERROR");
    $finish;
  end

endmodule
